// ===== design/pspr_pkg.sv =====
// ----------------------------------------------------------------------------
// Property section parser package
// Shared types, codes and the property id table for the section parser.
// ----------------------------------------------------------------------------
package pspr_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned SECTION_W = 28;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned USED_W    = 29;
  localparam int unsigned VCOUNT_W  = 3;

  // A varint may hold at most this many bytes.
  localparam logic [VCOUNT_W-1:0] VARINT_MAX_BYTES = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_LEN     = 4'd1,
    PH_ID      = 4'd2,
    PH_FIXED   = 4'd3,
    PH_VARINT  = 4'd4,
    PH_SLEN    = 4'd5,
    PH_CONTENT = 4'd6,
    PH_DONE    = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    TY_BYTE = 3'd0,
    TY_TWO  = 3'd1,
    TY_FOUR = 3'd2,
    TY_VAR  = 3'd3,
    TY_STR  = 3'd4,
    TY_BIN  = 3'd5,
    TY_PAIR = 3'd6,
    TY_NONE = 3'd7
  } ptype_t;

  typedef enum logic [2:0] {
    ROLE_LENGTH  = 3'd0,
    ROLE_ID      = 3'd1,
    ROLE_FIXED   = 3'd2,
    ROLE_VARINT  = 3'd3,
    ROLE_STRLEN  = 3'd4,
    ROLE_CONTENT = 3'd5,
    ROLE_IGNORED = 3'd6
  } role_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_PROTOCOL  = 2'd2
  } err_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              section_start;
    logic              last_byte;
  } pspr_word_t;

  typedef struct packed {
    phase_t               phase;
    logic [SECTION_W-1:0] section_remaining;
    logic [VCOUNT_W-1:0]  varint_count;
    logic [DATA_W-1:0]    current_id;
    ptype_t               current_type;
    logic [VALUE_W-1:0]   value_acc;
    logic [FIELD_W-1:0]   field_remaining;
    logic                 pair_half;
    logic [USED_W-1:0]    used_count;
  } pspr_state_t;

  typedef struct packed {
    role_t              byte_role;
    logic [DATA_W-1:0]  property_id;
    logic [DATA_W-1:0]  data_out;
    logic [VALUE_W-1:0] value;
    logic               value_done;
    logic               pair_part;
    logic               section_done;
    err_t               error_code;
    logic [USED_W-1:0]  bytes_used;
  } pspr_result_t;

  // Value type of each property id from the standard table.
  function automatic ptype_t id_type(input logic [DATA_W-1:0] id);
    ptype_t t;
    case (id) inside
      8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: t = TY_BYTE;
      8'h13, 8'h21, 8'h22, 8'h23:                             t = TY_TWO;
      8'h02, 8'h11, 8'h18, 8'h27:                             t = TY_FOUR;
      8'h0B:                                                  t = TY_VAR;
      8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F:        t = TY_STR;
      8'h09, 8'h16:                                           t = TY_BIN;
      8'h26:                                                  t = TY_PAIR;
      default:                                                t = TY_NONE;
    endcase
    return t;
  endfunction

endpackage

// ===== design/pspr_in_if.sv =====
// ----------------------------------------------------------------------------
// Property section parser input channel
// Valid/ready channel that carries one raw section byte per word.
// ----------------------------------------------------------------------------
interface pspr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       section_start;
  logic       last_byte;

  modport source (output valid, output data_byte, output section_start,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input section_start,
                  input last_byte, output ready);
endinterface

// ===== design/pspr_out_if.sv =====
// ----------------------------------------------------------------------------
// Property section parser result channel
// Valid/ready channel that carries the tagged result of one byte per word.
// ----------------------------------------------------------------------------
interface pspr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  property_id;
  logic [7:0]  data_out;
  logic [31:0] value;
  logic        value_done;
  logic        pair_part;
  logic        section_done;
  logic [1:0]  error_code;
  logic [28:0] bytes_used;

  modport source (output valid, output byte_role, output property_id,
                  output data_out, output value, output value_done,
                  output pair_part, output section_done, output error_code,
                  output bytes_used, input ready);
  modport sink   (input valid, input byte_role, input property_id,
                  input data_out, input value, input value_done,
                  input pair_part, input section_done, input error_code,
                  input bytes_used, output ready);
endinterface

// ===== design/pspr_in_reg.sv =====
// ----------------------------------------------------------------------------
// Property section parser input register
// Holds one incoming word until the parse stage takes it.
// ----------------------------------------------------------------------------
module pspr_in_reg (
  input  logic               clk,
  input  logic               rst,
  pspr_in_if.sink            stream,
  input  logic               advance,
  output logic               full,
  output pspr_pkg::pspr_word_t word
);

  // The register can take a new word when it is empty or being drained.
  assign stream.ready = !full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (stream.ready) begin
      full <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      word.data_byte     <= stream.data_byte;
      word.section_start <= stream.section_start;
      word.last_byte     <= stream.last_byte;
    end
  end

endmodule

// ===== design/pspr_step.sv =====
// ----------------------------------------------------------------------------
// Property section parser step logic
// Next parser state and tagged result for one byte.
// ----------------------------------------------------------------------------
module pspr_step (
  input  pspr_pkg::pspr_word_t   word,
  input  pspr_pkg::pspr_state_t  cur,
  output pspr_pkg::pspr_state_t  nxt,
  output pspr_pkg::pspr_result_t res
);

  pspr_pkg::pspr_state_t s;
  pspr_pkg::err_t        err;
  pspr_pkg::ptype_t      ty;
  logic                  body;
  logic                  complete;
  logic                  pair_switch;
  logic [2:0]            vcount;
  logic [4:0]            shamt;
  logic [31:0]           acc;
  logic [15:0]           fr;

  always_comb begin
    s = cur;
    if (word.section_start) begin
      s = '0;
      s.phase = pspr_pkg::PH_LEN;
    end
    nxt = s;

    res = '0;
    res.byte_role  = pspr_pkg::ROLE_IGNORED;
    res.error_code = pspr_pkg::ERR_NONE;
    res.bytes_used = s.used_count;

    err         = pspr_pkg::ERR_NONE;
    ty          = pspr_pkg::id_type(word.data_byte);
    body        = 1'b0;
    complete    = 1'b0;
    pair_switch = (s.current_type == pspr_pkg::TY_PAIR) && !s.pair_half;
    vcount      = s.varint_count + 3'd1;
    shamt       = 5'(s.varint_count[1:0]) * 5'd7;
    acc         = s.value_acc | (32'(word.data_byte[6:0]) << shamt);
    fr          = s.field_remaining - 16'd1;

    if (s.phase != pspr_pkg::PH_IDLE && s.phase != pspr_pkg::PH_DONE &&
        s.phase != pspr_pkg::PH_ERROR) begin
      nxt.used_count = s.used_count + 29'd1;
      res.bytes_used = nxt.used_count;
      res.data_out   = word.data_byte;
      body = (s.phase != pspr_pkg::PH_LEN);
      if (body && s.section_remaining != '0) begin
        nxt.section_remaining = s.section_remaining - 28'd1;
      end
      if (s.phase == pspr_pkg::PH_SLEN || s.phase == pspr_pkg::PH_CONTENT) begin
        res.property_id = s.current_id;
        res.pair_part   = (s.current_type == pspr_pkg::TY_PAIR) && s.pair_half;
      end

      case (s.phase)
        pspr_pkg::PH_LEN, pspr_pkg::PH_VARINT: begin
          if (s.phase == pspr_pkg::PH_LEN) begin
            res.byte_role = pspr_pkg::ROLE_LENGTH;
          end else begin
            res.byte_role   = pspr_pkg::ROLE_VARINT;
            res.property_id = s.current_id;
          end
          nxt.value_acc    = acc;
          nxt.varint_count = vcount;
          res.value        = acc;
          if (word.data_byte[7]) begin
            if (vcount >= pspr_pkg::VARINT_MAX_BYTES) begin
              err = pspr_pkg::ERR_MALFORMED;
            end
          end else begin
            res.value_done = 1'b1;
            if (s.phase == pspr_pkg::PH_LEN) begin
              nxt.section_remaining = acc[27:0];
              if (acc[27:0] == '0) begin
                nxt.phase        = pspr_pkg::PH_DONE;
                res.section_done = 1'b1;
              end else begin
                nxt.phase = pspr_pkg::PH_ID;
              end
            end else begin
              complete = 1'b1;
            end
          end
        end
        pspr_pkg::PH_ID: begin
          res.byte_role    = pspr_pkg::ROLE_ID;
          res.property_id  = word.data_byte;
          nxt.current_id   = word.data_byte;
          nxt.current_type = ty;
          nxt.pair_half    = 1'b0;
          nxt.value_acc    = '0;
          nxt.varint_count = '0;
          case (ty)
            pspr_pkg::TY_BYTE: begin
              nxt.phase           = pspr_pkg::PH_FIXED;
              nxt.field_remaining = 16'd1;
            end
            pspr_pkg::TY_TWO: begin
              nxt.phase           = pspr_pkg::PH_FIXED;
              nxt.field_remaining = 16'd2;
            end
            pspr_pkg::TY_FOUR: begin
              nxt.phase           = pspr_pkg::PH_FIXED;
              nxt.field_remaining = 16'd4;
            end
            pspr_pkg::TY_VAR: begin
              nxt.phase = pspr_pkg::PH_VARINT;
            end
            pspr_pkg::TY_NONE: begin
              err = pspr_pkg::ERR_PROTOCOL;
            end
            default: begin
              nxt.phase           = pspr_pkg::PH_SLEN;
              nxt.field_remaining = 16'd2;
            end
          endcase
        end
        pspr_pkg::PH_FIXED: begin
          res.byte_role       = pspr_pkg::ROLE_FIXED;
          res.property_id     = s.current_id;
          nxt.value_acc       = {s.value_acc[23:0], word.data_byte};
          res.value           = nxt.value_acc;
          nxt.field_remaining = fr;
          if (fr == '0) begin
            res.value_done = 1'b1;
            complete       = 1'b1;
          end
        end
        pspr_pkg::PH_SLEN: begin
          res.byte_role       = pspr_pkg::ROLE_STRLEN;
          nxt.value_acc       = {16'd0, s.value_acc[7:0], word.data_byte};
          res.value           = nxt.value_acc;
          nxt.field_remaining = fr;
          if (fr == '0) begin
            res.value_done      = 1'b1;
            nxt.field_remaining = nxt.value_acc[15:0];
            if (nxt.value_acc[15:0] == '0) begin
              // An empty key moves straight on to the value of a pair.
              if (pair_switch) begin
                nxt.pair_half       = 1'b1;
                nxt.value_acc       = '0;
                nxt.field_remaining = 16'd2;
                nxt.phase           = pspr_pkg::PH_SLEN;
              end else begin
                complete = 1'b1;
              end
            end else begin
              nxt.phase = pspr_pkg::PH_CONTENT;
            end
          end
        end
        default: begin
          res.byte_role       = pspr_pkg::ROLE_CONTENT;
          res.value           = s.value_acc;
          nxt.field_remaining = fr;
          if (fr == '0) begin
            if (pair_switch) begin
              nxt.pair_half       = 1'b1;
              nxt.value_acc       = '0;
              nxt.field_remaining = 16'd2;
              nxt.phase           = pspr_pkg::PH_SLEN;
            end else begin
              complete = 1'b1;
            end
          end
        end
      endcase

      if (err == pspr_pkg::ERR_NONE) begin
        if (complete) begin
          nxt.phase = pspr_pkg::PH_ID;
        end
        // The byte that uses up the section must also close a property.
        if (body && nxt.section_remaining == '0) begin
          if (nxt.phase == pspr_pkg::PH_ID) begin
            nxt.phase        = pspr_pkg::PH_DONE;
            res.section_done = 1'b1;
          end else begin
            err = pspr_pkg::ERR_MALFORMED;
          end
        end
      end
      if (err == pspr_pkg::ERR_NONE && word.last_byte &&
          nxt.phase != pspr_pkg::PH_DONE) begin
        err = pspr_pkg::ERR_MALFORMED;
      end
      if (err != pspr_pkg::ERR_NONE) begin
        nxt.phase        = pspr_pkg::PH_ERROR;
        res.section_done = 1'b0;
      end
      res.error_code = err;
    end
  end

endmodule

// ===== design/property_section_parser.sv =====
// A byte accepted into the input register is parsed from there into the registered result word.
// Throughput: one byte per cycle while the result channel is not stalled, set by the parser state update loop.
// The input register takes a new word while a finished result still waits, but only when it is empty.
// Reset (rst, synchronous, active high) empties both stages and returns the parser to idle.
// ----------------------------------------------------------------------------
// Property section parser
// Tags each byte of a property section with its role, builds values and
// lengths, and flags malformed or protocol errors, one byte per word.
// ----------------------------------------------------------------------------
module property_section_parser (
  input  logic      clk,
  input  logic      rst,
  pspr_in_if.sink   stream,
  pspr_out_if.source result
);

  pspr_pkg::pspr_word_t   word;
  pspr_pkg::pspr_state_t  state;
  pspr_pkg::pspr_state_t  state_next;
  pspr_pkg::pspr_result_t step_res;
  pspr_pkg::pspr_result_t res;
  logic                   full;
  logic                   advance;
  logic                   process;

  assign advance = !result.valid || result.ready;
  assign process = full && advance;

  pspr_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .advance (advance),
    .full    (full),
    .word    (word)
  );

  pspr_step u_step (
    .word (word),
    .cur  (state),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      // The all-zero state has the parser idle.
      state <= '0;
    end else if (process) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res <= step_res;
    end
  end

  assign result.byte_role    = res.byte_role;
  assign result.property_id  = res.property_id;
  assign result.data_out     = res.data_out;
  assign result.value        = res.value;
  assign result.value_done   = res.value_done;
  assign result.pair_part    = res.pair_part;
  assign result.section_done = res.section_done;
  assign result.error_code   = res.error_code;
  assign result.bytes_used   = res.bytes_used;

  a_done_no_error: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.section_done && result.error_code != pspr_pkg::ERR_NONE))
    else $error("section completion reported together with an error");

  a_error_enters_error_phase: assert property (@(posedge clk) disable iff (rst)
    (process && step_res.error_code != pspr_pkg::ERR_NONE)
      |=> (state.phase == pspr_pkg::PH_ERROR))
    else $error("parser did not stop after an error");

  a_done_ignores: assert property (@(posedge clk) disable iff (rst)
    (process && !word.section_start && state.phase == pspr_pkg::PH_DONE)
      |=> (result.valid && result.byte_role == pspr_pkg::ROLE_IGNORED))
    else $error("byte after a finished section was not ignored");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (full && result.valid && !result.ready) |-> !stream.ready)
    else $error("input taken while both stages are held");

endmodule
